FILE: sv/sclm_pkg.sv
package sclm_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 64;
  localparam int COUNT_W = 3;
  localparam int MASK_W = 6;
  localparam int CFG_INDEX_W = 4;

  localparam int LINE_LEN_DEFAULT = 8;
  localparam int NUM_COMMANDS_DEFAULT = 6;

  localparam logic [BYTE_W-1:0] DEFAULT_TERMINATOR = 8'h0D;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_COUNT = 4'd1;
  localparam int REG_WORD_BASE = 2;

endpackage

FILE: sv/sclm_line_buf.sv
module sclm_line_buf #(
  parameter int LINE_LEN = 8,
  parameter int POS_W = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_wr,
  input  logic                       line_clear,
  input  logic [sclm_pkg::BYTE_W-1:0] char_in,
  output logic [sclm_pkg::BYTE_W-1:0] chars [LINE_LEN],
  output logic [POS_W-1:0]           pos
);
  import sclm_pkg::*;

  logic [POS_W-1:0] pos_next;

  always_comb begin
    pos_next = pos;
    if (line_clear) begin
      pos_next = '0;
    end else if (char_wr) begin
      // wrap once the last slot is written, so the line restarts empty
      if (pos == POS_W'(LINE_LEN - 1)) begin
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (char_wr && !line_clear) begin
      chars[pos] <= char_in;
    end
  end

endmodule

FILE: sv/sclm_cmd_match.sv
module sclm_cmd_match #(
  parameter int LINE_LEN = 8,
  parameter int NUM_COMMANDS = 6,
  parameter int POS_W = 3
) (
  input  logic [sclm_pkg::BYTE_W-1:0]  chars [LINE_LEN],
  input  logic [POS_W-1:0]            pos,
  input  logic [sclm_pkg::WORD_W-1:0]  words [NUM_COMMANDS],
  input  logic [sclm_pkg::COUNT_W-1:0] command_count,
  output logic [sclm_pkg::MASK_W-1:0]  mask
);
  import sclm_pkg::*;

  logic [NUM_COMMANDS-1:0] hit;

  // A word equals the line when its first pos bytes match the buffered chars
  // and its byte at pos is NUL; buffered chars are printable, so never NUL.
  always_comb begin
    logic ok;
    for (int i = 0; i < NUM_COMMANDS; i++) begin
      ok = (words[i][BYTE_W*int'(pos) +: BYTE_W] == '0);
      for (int k = 0; k < LINE_LEN; k++) begin
        if (k < int'(pos) && words[i][BYTE_W*k +: BYTE_W] != chars[k]) begin
          ok = 1'b0;
        end
      end
      hit[i] = ok && (command_count > COUNT_W'(i));
    end
  end

  always_comb begin
    mask = '0;
    mask[NUM_COMMANDS-1:0] = hit;
  end

endmodule

FILE: sv/serial_command_line_matcher.sv
// Command line matcher for a serial receiver. One byte is taken per
// transaction on rx_byte, and a byte can be accepted in every clock cycle.
// Printable bytes build up a line of up to LINE_LEN-1 characters (the line
// restarts empty once LINE_LEN characters are written); the terminator byte
// compares the line against the first command_count command words
// combinationally and places the match mask in the output register,
// valid in the cycle after the terminator is accepted. A terminator is
// held off only while the output register still holds an untaken result;
// other bytes are always taken. Configuration writes are never held off
// and must be made while the block is idle.
module serial_command_line_matcher #(
  parameter int LINE_LEN = sclm_pkg::LINE_LEN_DEFAULT,
  parameter int NUM_COMMANDS = sclm_pkg::NUM_COMMANDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sclm_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sclm_pkg::MASK_W-1:0]      matched_mask,
  output logic                            any_match,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sclm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sclm_pkg::WORD_W-1:0]      cfg_data
);
  import sclm_pkg::*;

  localparam int POS_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

  logic [BYTE_W-1:0]  terminator;
  logic [COUNT_W-1:0] command_count;
  logic [WORD_W-1:0]  words [NUM_COMMANDS];

  logic [BYTE_W-1:0]  chars [LINE_LEN];
  logic [POS_W-1:0]   pos;
  logic [MASK_W-1:0]  mask;

  logic in_accept;
  logic out_take;
  logic is_term;
  logic is_print;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign is_term   = (rx_byte == terminator);
  assign is_print  = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
  assign out_take  = out_valid && !out_stall;
  // only a terminator needs the output register
  assign in_stall  = out_valid && out_stall && is_term;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator    <= DEFAULT_TERMINATOR;
      command_count <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_TERMINATOR:    terminator    <= cfg_data[BYTE_W-1:0];
        REG_COMMAND_COUNT: command_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        words[i] <= '0;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        if (cfg_index == CFG_INDEX_W'(REG_WORD_BASE + i)) begin
          words[i] <= cfg_data;
        end
      end
    end
  end

  sclm_line_buf #(
    .LINE_LEN(LINE_LEN),
    .POS_W   (POS_W)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .char_wr   (in_accept && is_print),
    .line_clear(in_accept && is_term),
    .char_in   (rx_byte),
    .chars     (chars),
    .pos       (pos)
  );

  sclm_cmd_match #(
    .LINE_LEN    (LINE_LEN),
    .NUM_COMMANDS(NUM_COMMANDS),
    .POS_W       (POS_W)
  ) u_cmd_match (
    .chars        (chars),
    .pos          (pos),
    .words        (words),
    .command_count(command_count),
    .mask         (mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && is_term) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_term) begin
      matched_mask <= mask;
      any_match    <= (mask != '0);
    end
  end

`ifndef SYNTHESIS
  a_term_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && is_term |=> out_valid)
    else $error("terminator accepted but no result registered");

  a_term_clears_pos: assert property (@(posedge clk) disable iff (rst)
    in_accept && is_term |=> pos == '0)
    else $error("line position not cleared by terminator");

  a_char_advances: assert property (@(posedge clk) disable iff (rst)
    in_accept && is_print && !is_term && pos != POS_W'(LINE_LEN - 1)
    |=> pos == $past(pos) + POS_W'(1))
    else $error("line position did not advance on a printable byte");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && is_term)
    else $error("input stalled with the output register free");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (matched_mask >> NUM_COMMANDS) == '0)
    else $error("mask bit set beyond the command slots");
`endif

endmodule
